### hw/rtl/pbde_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pbde_pkg: shared types and constants of the depex evaluator
// Opcodes, status codes, stack geometry and the words passed between modules.
// ----------------------------------------------------------------------------
package pbde_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;

    localparam logic [7:0] OP_BEFORE       = 8'h00;
    localparam logic [7:0] OP_AFTER        = 8'h01;
    localparam logic [7:0] OP_PUSH         = 8'h02;
    localparam logic [7:0] OP_AND          = 8'h03;
    localparam logic [7:0] OP_OR           = 8'h04;
    localparam logic [7:0] OP_NOT          = 8'h05;
    localparam logic [7:0] OP_TRUE         = 8'h06;
    localparam logic [7:0] OP_FALSE        = 8'h07;
    localparam logic [7:0] OP_END          = 8'h08;
    localparam logic [7:0] OP_REPLACE_TRUE = 8'hff;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_UNDERFLOW = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_UNKNOWN   = 3'd3,
        ST_PAST_END  = 3'd4,
        ST_MISPLACED = 3'd5
    } status_t;

    typedef struct packed {
        logic       start_expression;
        logic [7:0] opcode;
        logic       protocol_found;
        logic       last_in_buffer;
    } instr_t;

    typedef struct packed {
        logic    finished;
        logic    schedulable;
        status_t status;
        logic    mark_replace;
    } result_t;

    typedef struct packed {
        logic [CNT_W-1:0] stack_count;
        logic             evaluation_done;
    } core_stat_t;

endpackage

`default_nettype wire

### hw/rtl/pbde_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pbde_core: bit stack and instruction evaluation
// Top two entries live in registers; deeper entries live in a synchronous
// memory whose next pop value is prefetched every cycle, with write bypass.
// ----------------------------------------------------------------------------
module pbde_core
    import pbde_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       fire,
    input  wire instr_t     instr,
    output result_t         result,
    output core_stat_t      stat
);

    logic [CNT_W-1:0]  count_reg, count_next;
    logic              done_reg, done_next;
    logic              t0_reg, t0_next;
    logic              t1_reg, t1_next;
    logic              rd_reg;

    logic              mem [STACK_DEPTH];
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;

    logic [CNT_W-1:0]  cnt_eff;
    logic              active;
    logic              full;
    logic              do_push;
    logic              push_val;
    logic              fin;
    logic              verdict;
    status_t           status;
    logic              mark;
    logic [CNT_W-1:0]  cnt_calc;
    logic              t0_calc;
    logic              t1_calc;

    assign cnt_eff = instr.start_expression ? '0 : count_reg;
    assign active  = instr.start_expression | ~done_reg;
    assign full    = (cnt_eff == CNT_W'(STACK_DEPTH));

    always_comb begin
        fin      = 1'b0;
        verdict  = 1'b0;
        status   = ST_OK;
        mark     = 1'b0;
        do_push  = 1'b0;
        push_val = 1'b0;
        cnt_calc = cnt_eff;
        t0_calc  = t0_reg;
        t1_calc  = t1_reg;
        if (active) begin
            unique case (instr.opcode) inside
                OP_BEFORE, OP_AFTER: begin
                    fin    = 1'b1;
                    status = ST_MISPLACED;
                end
                OP_PUSH: begin
                    mark     = instr.protocol_found;
                    do_push  = 1'b1;
                    push_val = instr.protocol_found;
                end
                OP_AND, OP_OR: begin
                    if (cnt_eff < CNT_W'(2)) begin
                        fin    = 1'b1;
                        status = ST_UNDERFLOW;
                    end else begin
                        t0_calc  = (instr.opcode == OP_AND) ? (t0_reg & t1_reg)
                                                             : (t0_reg | t1_reg);
                        t1_calc  = rd_reg;
                        cnt_calc = cnt_eff - CNT_W'(1);
                    end
                end
                OP_NOT: begin
                    if (cnt_eff == '0) begin
                        fin    = 1'b1;
                        status = ST_UNDERFLOW;
                    end else begin
                        t0_calc = ~t0_reg;
                    end
                end
                OP_TRUE, OP_REPLACE_TRUE: begin
                    do_push  = 1'b1;
                    push_val = 1'b1;
                end
                OP_FALSE: begin
                    do_push  = 1'b1;
                    push_val = 1'b0;
                end
                OP_END: begin
                    fin = 1'b1;
                    if (cnt_eff == '0) begin
                        status = ST_UNDERFLOW;
                    end else begin
                        verdict  = t0_reg;
                        t0_calc  = t1_reg;
                        t1_calc  = rd_reg;
                        cnt_calc = cnt_eff - CNT_W'(1);
                    end
                end
                default: begin
                    fin    = 1'b1;
                    status = ST_UNKNOWN;
                end
            endcase
            if (do_push) begin
                if (full) begin
                    fin     = 1'b1;
                    status  = ST_OVERFLOW;
                    do_push = 1'b0;
                end else begin
                    t0_calc  = push_val;
                    t1_calc  = t0_reg;
                    cnt_calc = cnt_eff + CNT_W'(1);
                end
            end
            if (!fin && instr.last_in_buffer) begin
                fin    = 1'b1;
                status = ST_PAST_END;
            end
        end
    end

    always_comb begin
        count_next = count_reg;
        done_next  = done_reg;
        t0_next    = t0_reg;
        t1_next    = t1_reg;
        if (fire && active) begin
            count_next = cnt_calc;
            done_next  = fin;
            t0_next    = t0_calc;
            t1_next    = t1_calc;
        end
    end

    // spill second entry to memory when a push buries it
    assign wr_en   = fire && do_push && (cnt_eff >= CNT_W'(2));
    assign wr_addr = ADDR_W'(cnt_eff - CNT_W'(2));
    // prefetch the entry that sits below the register pair after this word
    assign rd_addr = ADDR_W'(count_next - CNT_W'(3));

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= t1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en && (wr_addr == rd_addr)) begin
            rd_reg <= t1_reg;
        end else begin
            rd_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        t0_reg <= t0_next;
        t1_reg <= t1_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            done_reg  <= 1'b1;
        end else begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    assign result.finished     = fin;
    assign result.schedulable  = verdict;
    assign result.status       = status;
    assign result.mark_replace = mark;

    assign stat.stack_count     = count_reg;
    assign stat.evaluation_done = done_reg;

endmodule

`default_nettype wire

### hw/rtl/postfix_boolean_depex_evaluator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// postfix_boolean_depex_evaluator: dependency-expression evaluator
// Streams depex instructions in, returns one result word per instruction.
// ----------------------------------------------------------------------------
// Takes one instruction word per cycle and returns one result word for each,
// in the following cycle, through an output register; back pressure on the result
// side stalls the input only while that register is full. Sustained rate is
// one word per cycle, set by the single read and single write per cycle of
// the stack memory: the top two stack bits sit in registers and the entry
// below them is prefetched every cycle. Raise tuser on the first word of an
// expression; tlast on a result word marks the verdict. No clearing pass
// follows reset.
module postfix_boolean_depex_evaluator
    import pbde_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [7:0] opcode, [8] protocol_found, zero fill
    input  wire logic        s_tuser,   // [0] start_expression
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [0] schedulable, [3:1] status, [4] mark_replace
    output logic             m_tlast
);

    logic       fire;
    instr_t     instr;
    result_t    core_result;
    core_stat_t stat;
    result_t    result_reg;
    logic       m_valid_reg, m_valid_next;

    assign s_tready = ~m_valid_reg | m_tready;
    assign fire     = s_tvalid & s_tready;

    assign instr.start_expression = s_tuser;
    assign instr.opcode           = s_tdata[7:0];
    assign instr.protocol_found   = s_tdata[8];
    assign instr.last_in_buffer   = s_tlast;

    pbde_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .instr   (instr),
        .result  (core_result),
        .stat    (stat)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (fire) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            result_reg <= core_result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = result_reg.finished;
    assign m_tdata  = {3'b000, result_reg.mark_replace, result_reg.status,
                       result_reg.schedulable};

    assert property (@(posedge aclk) disable iff (!aresetn)
        stat.stack_count <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (result_reg.status != ST_OK)
        |-> result_reg.finished && !result_reg.schedulable)
        else $error("error result without false verdict");

    assert property (@(posedge aclk) disable iff (!aresetn)
        fire && s_tuser && (s_tdata[7:0] == OP_TRUE) && !s_tlast
        |=> (stat.stack_count == CNT_W'(1)) && !stat.evaluation_done)
        else $error("start with TRUE did not leave one entry");

endmodule

`default_nettype wire

### verif/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: stream testbench for the depex evaluator
// Sends instruction words on the slave side and checks every result word on
// the master side against a bit-stack predictor kept in the bench. Covers
// directed corner cases, stack overflow at full depth, random well-formed
// expressions and random noise, with random gaps and back pressure.
// ----------------------------------------------------------------------------
module tb_top
    import pbde_pkg::*;
();

    localparam logic [7:0] OP_UNKNOWN_LOW  = 8'h09;
    localparam logic [7:0] OP_UNKNOWN_HIGH = 8'hfe;
    localparam int         STALL_LIMIT     = 4000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    bit [STACK_DEPTH-1:0] model_stack = '0;
    int                   model_depth = 0;
    bit                   model_done  = 1'b1;

    result_t verdict_q[$];
    bit      no_idle         = 1'b0;
    int      words_sent      = 0;
    int      results_checked = 0;
    int      true_verdicts   = 0;
    int      false_verdicts  = 0;
    int      error_endings   = 0;
    int      failures        = 0;
    int      stall_cycles    = 0;

    always #4 aclk = ~aclk;

    postfix_boolean_depex_evaluator i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    function automatic bit stack_push(input bit v);
        if (model_depth >= STACK_DEPTH) return 1'b0;
        model_stack[model_depth] = v;
        model_depth++;
        return 1'b1;
    endfunction

    function automatic result_t evaluate_word(input instr_t w);
        result_t r;
        bit      a;
        bit      b;
        r = '0;
        if (w.start_expression) begin
            model_depth = 0;
            model_done  = 1'b0;
        end
        if (!model_done) begin
            case (w.opcode)
                OP_BEFORE, OP_AFTER: begin
                    r.finished = 1'b1;
                    r.status   = ST_MISPLACED;
                end
                OP_PUSH: begin
                    r.mark_replace = w.protocol_found;
                    if (!stack_push(w.protocol_found)) begin
                        r.finished = 1'b1;
                        r.status   = ST_OVERFLOW;
                    end
                end
                OP_AND, OP_OR: begin
                    if (model_depth < 2) begin
                        r.finished = 1'b1;
                        r.status   = ST_UNDERFLOW;
                    end else begin
                        a = model_stack[model_depth-1];
                        b = model_stack[model_depth-2];
                        model_stack[model_depth-2] = (w.opcode == OP_AND) ? (a & b) : (a | b);
                        model_depth--;
                    end
                end
                OP_NOT: begin
                    if (model_depth < 1) begin
                        r.finished = 1'b1;
                        r.status   = ST_UNDERFLOW;
                    end else begin
                        model_stack[model_depth-1] = ~model_stack[model_depth-1];
                    end
                end
                OP_TRUE, OP_REPLACE_TRUE, OP_FALSE: begin
                    if (!stack_push(w.opcode != OP_FALSE)) begin
                        r.finished = 1'b1;
                        r.status   = ST_OVERFLOW;
                    end
                end
                OP_END: begin
                    r.finished = 1'b1;
                    if (model_depth < 1) begin
                        r.status = ST_UNDERFLOW;
                    end else begin
                        r.schedulable = model_stack[model_depth-1];
                        model_depth--;
                    end
                end
                default: begin
                    r.finished = 1'b1;
                    r.status   = ST_UNKNOWN;
                end
            endcase
            if (!r.finished && w.last_in_buffer) begin
                r.finished = 1'b1;
                r.status   = ST_PAST_END;
            end
            if (r.finished) model_done = 1'b1;
        end
        return r;
    endfunction

    // 0..3 leaf opcodes, 4..9 the rest of the instruction set
    function automatic logic [7:0] pick_opcode(input int unsigned hi);
        case ($urandom_range(0, hi))
            0:       return OP_TRUE;
            1:       return OP_FALSE;
            2:       return OP_PUSH;
            3:       return OP_REPLACE_TRUE;
            4:       return OP_AND;
            5:       return OP_OR;
            6:       return OP_NOT;
            7:       return OP_END;
            8:       return OP_BEFORE;
            default: return OP_AFTER;
        endcase
    endfunction

    task automatic send_word(input bit start, input logic [7:0] op, input bit found,
                             input bit last);
        instr_t w;
        w.start_expression = start;
        w.opcode           = op;
        w.protocol_found   = found;
        w.last_in_buffer   = last;
        while (!no_idle && $urandom_range(0, 99) < 29) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, found, op};
        s_tuser  <= start;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        verdict_q.push_back(evaluate_word(w));
        words_sent++;
    endtask

    task automatic test_directed();
        // idle evaluator ignores words without a start
        send_word(1'b0, OP_PUSH, 1'b1, 1'b1);
        send_word(1'b1, OP_TRUE, 1'b0, 1'b0);
        send_word(1'b0, OP_FALSE, 1'b0, 1'b0);
        send_word(1'b0, OP_AND, 1'b0, 1'b0);
        send_word(1'b0, OP_NOT, 1'b0, 1'b0);
        send_word(1'b0, OP_PUSH, 1'b1, 1'b0);
        send_word(1'b0, OP_OR, 1'b0, 1'b0);
        send_word(1'b0, OP_REPLACE_TRUE, 1'b0, 1'b0);
        send_word(1'b0, OP_AND, 1'b0, 1'b0);
        send_word(1'b0, OP_END, 1'b0, 1'b0);
        send_word(1'b1, OP_PUSH, 1'b0, 1'b0);
        send_word(1'b0, OP_END, 1'b1, 1'b1);
        send_word(1'b1, OP_BEFORE, 1'b0, 1'b0);
        send_word(1'b1, OP_AFTER, 1'b1, 1'b0);
        send_word(1'b1, OP_UNKNOWN_LOW, 1'b0, 1'b0);
        send_word(1'b1, OP_UNKNOWN_HIGH, 1'b1, 1'b1);
        send_word(1'b1, OP_AND, 1'b0, 1'b0);
        send_word(1'b1, OP_TRUE, 1'b0, 1'b0);
        send_word(1'b0, OP_OR, 1'b0, 1'b0);
        send_word(1'b1, OP_NOT, 1'b0, 1'b0);
        send_word(1'b1, OP_END, 1'b0, 1'b0);
        send_word(1'b1, OP_TRUE, 1'b0, 1'b1);
        send_word(1'b0, OP_TRUE, 1'b0, 1'b0);
        // restart in mid expression drops the stack
        send_word(1'b1, OP_TRUE, 1'b0, 1'b0);
        send_word(1'b1, OP_END, 1'b0, 1'b0);
    endtask

    task automatic test_stack_overflow();
        logic [7:0] extra;
        for (int k = 0; k < 5; k++) begin
            send_word(1'b1, pick_opcode(3), 1'($urandom_range(0, 1)), 1'b0);
            for (int n = 1; n < STACK_DEPTH; n++) begin
                send_word(1'b0, pick_opcode(3), 1'($urandom_range(0, 1)), 1'b0);
            end
            case (k)
                0:       extra = OP_PUSH;
                1:       extra = OP_TRUE;
                2:       extra = OP_FALSE;
                3:       extra = OP_REPLACE_TRUE;
                default: extra = OP_NOT;
            endcase
            send_word(1'b0, extra, 1'b1, 1'b0);
            if (extra == OP_NOT) begin
                // fold a full stack back down to the verdict
                for (int n = 1; n < STACK_DEPTH; n++) begin
                    send_word(1'b0, $urandom_range(0, 1) ? OP_AND : OP_OR, 1'b0, 1'b0);
                end
                send_word(1'b0, OP_END, 1'b0, 1'b1);
            end
        end
    endtask

    task automatic test_random_expressions();
        int unsigned target;
        int unsigned pushed;
        int unsigned depth;
        int unsigned bias;
        int unsigned roll;
        int          cut;
        int          idx;
        int          quiet_until;
        logic [7:0]  op;
        quiet_until = words_sent + 250;
        no_idle     = 1'b1;
        while (words_sent < 1250) begin
            roll = $urandom_range(0, 99);
            if (roll < 80) target = $urandom_range(1, 8);
            else if (roll < 95) target = $urandom_range(9, 40);
            else target = $urandom_range(41, STACK_DEPTH);
            bias = (roll >= 95 && $urandom_range(0, 1)) ? 10 : $urandom_range(3, 7);
            cut  = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 2 * target)) : -1;
            pushed = 0;
            depth  = 0;
            idx    = 0;
            while (!(pushed == target && depth == 1)) begin
                roll = $urandom_range(0, 9);
                if (pushed < target && (depth < 2 || roll < bias)) begin
                    op = pick_opcode(3);
                    pushed++;
                    depth++;
                end else if (depth >= 2 && roll != 9) begin
                    op = $urandom_range(0, 1) ? OP_AND : OP_OR;
                    depth--;
                end else begin
                    op = OP_NOT;
                end
                send_word(idx == 0, op, 1'($urandom_range(0, 1)), idx == cut);
                idx++;
            end
            send_word(1'b0, OP_END, 1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0);
            if (words_sent >= quiet_until) no_idle = 1'b0;
        end
        no_idle = 1'b0;
    endtask

    task automatic test_random_noise();
        logic [7:0] op;
        for (int n = 0; n < 300; n++) begin
            op = ($urandom_range(0, 99) < 30) ? 8'($urandom_range(0, 255)) : pick_opcode(9);
            send_word($urandom_range(0, 99) < 20, op, 1'($urandom_range(0, 1)),
                      $urandom_range(0, 99) < 10);
        end
    endtask

    always @(posedge aclk) begin
        m_tready <= no_idle || ($urandom_range(0, 99) >= 29);
    end

    function automatic void compare_field(input string what, input logic [7:0] want,
                                          input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
            failures++;
        end
    endfunction

    always @(posedge aclk) begin : check_results
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected result word, expected none actual %0h last %b",
                         $time, m_tdata, m_tlast);
                failures++;
            end else begin
                want = verdict_q.pop_front();
                results_checked++;
                if (want.finished) begin
                    if (want.status != ST_OK) error_endings++;
                    else if (want.schedulable) true_verdicts++;
                    else false_verdicts++;
                end
                compare_field("finished", 8'(want.finished), 8'(m_tlast));
                compare_field("schedulable", 8'(want.schedulable), 8'(m_tdata[0]));
                compare_field("status", 8'(want.status), 8'(m_tdata[3:1]));
                compare_field("mark_replace", 8'(want.mark_replace), 8'(m_tdata[4]));
                compare_field("fill bits", 8'd0, 8'(m_tdata[7:5]));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("FAIL postfix_boolean_depex_evaluator");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_stack_overflow();
        test_random_expressions();
        test_random_noise();
        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        $display("Sent %0d instruction words, checked %0d result words.",
                 words_sent, results_checked);
        $display("Endings: %0d true verdicts, %0d false verdicts, %0d on an error status.",
                 true_verdicts, false_verdicts, error_endings);
        if (failures == 0) begin
            $display("PASS postfix_boolean_depex_evaluator");
        end else begin
            $display("FAIL postfix_boolean_depex_evaluator");
        end
        $finish;
    end

endmodule

`default_nettype wire
